>>> hw/rtl/mtmie_pkg.sv
package mtmie_pkg;

  typedef logic [31:0] word_t;

  // operand and field widths
  localparam int unsigned OPC_W = 5;
  localparam int unsigned OPND_W = 24;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned IOEV_W = 2;

  // opcodes
  localparam logic [OPC_W-1:0] OP_NOP  = 5'h00;
  localparam logic [OPC_W-1:0] OP_MOV  = 5'h01;
  localparam logic [OPC_W-1:0] OP_ADD  = 5'h02;
  localparam logic [OPC_W-1:0] OP_SUB  = 5'h03;
  localparam logic [OPC_W-1:0] OP_INT  = 5'h04;
  localparam logic [OPC_W-1:0] OP_JMP  = 5'h05;
  localparam logic [OPC_W-1:0] OP_JNZ  = 5'h06;
  localparam logic [OPC_W-1:0] OP_HLT  = 5'h07;
  localparam logic [OPC_W-1:0] OP_PUSH = 5'h08;
  localparam logic [OPC_W-1:0] OP_POP  = 5'h09;
  localparam logic [OPC_W-1:0] OP_NOT  = 5'h0A;
  localparam logic [OPC_W-1:0] OP_AND  = 5'h0B;
  localparam logic [OPC_W-1:0] OP_OR   = 5'h0C;
  localparam logic [OPC_W-1:0] OP_XOR  = 5'h0D;
  localparam logic [OPC_W-1:0] OP_SHL  = 5'h0E;
  localparam logic [OPC_W-1:0] OP_SHR  = 5'h0F;
  localparam logic [OPC_W-1:0] OP_CMP  = 5'h10;
  localparam logic [OPC_W-1:0] OP_JG   = 5'h11;
  localparam logic [OPC_W-1:0] OP_JL   = 5'h12;
  localparam logic [OPC_W-1:0] OP_JZ   = 5'h13;
  localparam logic [OPC_W-1:0] OP_LOOP = 5'h14;
  localparam logic [OPC_W-1:0] OP_RST  = 5'h15;
  localparam logic [OPC_W-1:0] OP_IN   = 5'h16;
  localparam logic [OPC_W-1:0] OP_OUT  = 5'h17;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_JUMP  = 3'd1;
  localparam logic [STAT_W-1:0] ST_HALT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_ERR   = 3'd3;
  localparam logic [STAT_W-1:0] ST_RESET = 3'd4;

  // io event codes
  localparam logic [IOEV_W-1:0] IO_NONE = 2'd0;
  localparam logic [IOEV_W-1:0] IO_INT  = 2'd1;
  localparam logic [IOEV_W-1:0] IO_IN   = 2'd2;
  localparam logic [IOEV_W-1:0] IO_OUT  = 2'd3;

  // loop counter wrap values
  localparam word_t ALL_ONES = 32'hFFFF_FFFF;
  localparam word_t IMM_MAX  = 32'h00FF_FFFF;

endpackage

>>> hw/rtl/memory_to_memory_instruction_executor.sv
// result: registered as execute ends; execute holds while a result is untaken
// flow: one item at a time, set by the single data memory port
//   (source read, destination read, then compute and write-back)
// reset: synchronous; clears stack depth, last result and the result valid,
//   then a clearing pass zeroes the data memory, during which s_tready stays low
module memory_to_memory_instruction_executor
  import mtmie_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = 16,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[4:0], dst_value[28:5], src_value[52:29], loop_limit[76:53], zeros
  input  logic [79:0] s_tdata,
  // dst_is_addr[0], src_is_addr[1]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], jump_target[34:3], io_value[66:35], zeros
  output logic [71:0] m_tdata,
  // io_event[1:0]
  output logic [1:0]  m_tuser
);

  localparam int unsigned MEM_WORDS = 2 ** MEM_ADDR_BITS;
  localparam int unsigned SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SDW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_DST   = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state;
  logic [MEM_ADDR_BITS-1:0] clr_addr;

  // latched item fields
  logic [OPC_W-1:0]  opcode;
  logic              dst_is_addr;
  logic [OPND_W-1:0] dst_value;
  logic [OPND_W-1:0] loop_limit;
  word_t             sval;
  logic              src_is_addr_q;

  logic [SDW-1:0] stack_depth;
  word_t          last_result;

  // output register
  logic [STAT_W-1:0] out_status;
  word_t             out_target;
  logic [IOEV_W-1:0] out_ioev;
  word_t             out_ioval;

  // memories
  word_t dmem [0:MEM_WORDS-1];
  word_t dmem_rdata;
  logic  dmem_we;
  logic  dmem_re;
  logic [MEM_ADDR_BITS-1:0] dmem_addr;
  word_t dmem_wdata;

  word_t stk [0:STACK_DEPTH-1];
  word_t stk_rdata;
  logic [SIW-1:0] stk_top;

  logic accept;
  logic proceed;
  logic [OPND_W-1:0] s_src_value;

  // exec results
  word_t dval;
  logic [STAT_W-1:0] ex_status;
  word_t ex_target;
  logic [IOEV_W-1:0] ex_ioev;
  word_t ex_ioval;
  logic  ex_mem_we;
  word_t ex_mem_val;
  logic  ex_lr_we;
  word_t ex_lr_val;
  logic  ex_push;
  logic  ex_pop;
  word_t r_dec;
  word_t r_inc;

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign proceed = !m_tvalid || m_tready;
  assign s_src_value = s_tdata[52:29];

  assign m_tdata = {5'd0, out_ioval, out_target, out_status};
  assign m_tuser = out_ioev;

  // data memory port: one access per cycle
  always_comb begin
    dmem_we = 1'b0;
    dmem_re = 1'b0;
    dmem_addr = dst_value[MEM_ADDR_BITS-1:0];
    dmem_wdata = ex_mem_val;
    case (state)
      S_CLEAR: begin
        dmem_we = 1'b1;
        dmem_addr = clr_addr;
        dmem_wdata = '0;
      end
      S_IDLE: begin
        dmem_re = accept;
        dmem_addr = s_src_value[MEM_ADDR_BITS-1:0];
      end
      S_DST: begin
        dmem_re = 1'b1;
      end
      S_EXEC: begin
        dmem_we = proceed && ex_mem_we;
      end
      default: begin
        dmem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dmem[dmem_addr] <= dmem_wdata;
    end else if (dmem_re) begin
      dmem_rdata <= dmem[dmem_addr];
    end
  end

  // stack memory: top entry read while the destination is fetched
  assign stk_top = SIW'(stack_depth - SDW'(1));

  always_ff @(posedge clk) begin
    if (state == S_EXEC && proceed && ex_push) begin
      stk[stack_depth[SIW-1:0]] <= dval;
    end
    if (state == S_DST) begin
      stk_rdata <= stk[stk_top];
    end
  end

  // execute
  assign dval = dst_is_addr ? dmem_rdata : {8'd0, dst_value};
  assign r_dec = dmem_rdata - 32'd3;
  assign r_inc = dmem_rdata + 32'd3;

  always_comb begin
    ex_status = ST_OK;
    ex_target = '0;
    ex_ioev = IO_NONE;
    ex_ioval = '0;
    ex_mem_we = 1'b0;
    ex_mem_val = '0;
    ex_lr_we = 1'b0;
    ex_lr_val = '0;
    ex_push = 1'b0;
    ex_pop = 1'b0;
    case (opcode)
      OP_NOP: begin
        ex_status = ST_OK;
      end
      OP_MOV, OP_ADD, OP_SUB, OP_NOT, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
        if (!dst_is_addr) begin
          ex_status = ST_ERR;
        end else begin
          case (opcode)
            OP_MOV: ex_mem_val = sval;
            OP_ADD: ex_mem_val = dmem_rdata + sval;
            OP_SUB: ex_mem_val = dmem_rdata - sval;
            OP_NOT: ex_mem_val = ~dmem_rdata;
            OP_AND: ex_mem_val = dmem_rdata & sval;
            OP_OR:  ex_mem_val = dmem_rdata | sval;
            OP_XOR: ex_mem_val = dmem_rdata ^ sval;
            OP_SHL: ex_mem_val = dmem_rdata << sval[4:0];
            default: ex_mem_val = dmem_rdata >> sval[4:0];
          endcase
          ex_mem_we = 1'b1;
          ex_lr_we = 1'b1;
          ex_lr_val = ex_mem_val;
        end
      end
      OP_INT, OP_OUT: begin
        ex_ioev = (opcode == OP_INT) ? IO_INT : IO_OUT;
        ex_ioval = dval;
        ex_lr_we = 1'b1;
        ex_lr_val = dval;
      end
      OP_JMP, OP_JNZ, OP_JG, OP_JL, OP_JZ: begin
        if ((opcode == OP_JMP) ||
            (opcode == OP_JNZ && last_result != '0) ||
            (opcode == OP_JG && last_result != '0 && !last_result[31]) ||
            (opcode == OP_JL && last_result[31]) ||
            (opcode == OP_JZ && last_result == '0)) begin
          ex_status = ST_JUMP;
          ex_target = {dval[30:0], 1'b0} + dval;
          ex_lr_we = 1'b1;
          ex_lr_val = ex_target;
        end
      end
      OP_HLT: begin
        ex_status = ST_HALT;
      end
      OP_RST: begin
        ex_status = ST_RESET;
      end
      OP_PUSH: begin
        if (stack_depth >= SDW'(STACK_DEPTH)) begin
          ex_status = ST_ERR;
        end else begin
          ex_push = 1'b1;
          ex_lr_we = 1'b1;
          ex_lr_val = dval;
        end
      end
      OP_POP: begin
        if (stack_depth == '0 || !dst_is_addr) begin
          ex_status = ST_ERR;
        end else begin
          ex_pop = 1'b1;
          ex_mem_we = 1'b1;
          ex_mem_val = stk_rdata;
          ex_lr_we = 1'b1;
          ex_lr_val = stk_rdata;
        end
      end
      OP_CMP: begin
        ex_lr_we = 1'b1;
        ex_lr_val = dval - sval;
      end
      OP_LOOP: begin
        if (!dst_is_addr) begin
          ex_status = ST_ERR;
        end else if (loop_limit == '0) begin
          // count down
          if (dmem_rdata != '0) begin
            ex_status = ST_JUMP;
            ex_target = sval;
            ex_mem_we = 1'b1;
            ex_mem_val = (r_dec == ALL_ONES) ? IMM_MAX : r_dec;
          end
        end else if (dmem_rdata < {8'd0, loop_limit}) begin
          // count up
          ex_status = ST_JUMP;
          ex_target = sval;
          ex_mem_we = 1'b1;
          ex_mem_val = (r_inc == IMM_MAX) ? '0 : r_inc;
        end
      end
      OP_IN: begin
        if (!dst_is_addr) begin
          ex_status = ST_ERR;
        end else begin
          ex_ioev = IO_IN;
          ex_ioval = {8'd0, dst_value};
          ex_lr_we = 1'b1;
          ex_lr_val = {8'd0, dst_value};
        end
      end
      default: begin
        ex_status = ST_ERR;
      end
    endcase
  end

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      stack_depth <= '0;
      last_result <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result valid: set on a new result, cleared once taken
      if (state == S_EXEC && proceed) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MEM_ADDR_BITS'(1);
          if (clr_addr == MEM_ADDR_BITS'(MEM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_DST;
          end
        end
        S_DST: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (proceed) begin
            state <= S_IDLE;
            if (ex_lr_we) begin
              last_result <= ex_lr_val;
            end
            if (ex_push) begin
              stack_depth <= stack_depth + SDW'(1);
            end else if (ex_pop) begin
              stack_depth <= stack_depth - SDW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode <= s_tdata[4:0];
      dst_value <= s_tdata[28:5];
      loop_limit <= s_tdata[76:53];
      dst_is_addr <= s_tuser[0];
      // source immediate held until its memory read returns
      sval <= {8'd0, s_src_value};
    end else if (state == S_DST && src_is_addr_q) begin
      sval <= dmem_rdata;
    end
    if (state == S_EXEC && proceed) begin
      out_status <= ex_status;
      out_target <= ex_target;
      out_ioev <= ex_ioev;
      out_ioval <= ex_ioval;
    end
  end

  // source operand kind
  always_ff @(posedge clk) begin
    if (accept) begin
      src_is_addr_q <= s_tuser[1];
    end
  end

endmodule

>>> tb/sv/tb_memory_to_memory_instruction_executor.sv
module tb_memory_to_memory_instruction_executor;
  import mtmie_pkg::*;

  localparam int unsigned MEM_BITS = 16;
  localparam int unsigned STACK_SIZE = 32;

  // opcodes with no defined instruction
  localparam logic [OPC_W-1:0] OP_FIRST_UNUSED = 5'h18;
  localparam logic [OPC_W-1:0] OP_LAST_UNUSED  = 5'h1F;

  localparam logic [OPC_W-1:0] ALU_OPS [0:8] = '{OP_MOV, OP_ADD, OP_SUB, OP_NOT, OP_AND,
                                                 OP_OR, OP_XOR, OP_SHL, OP_SHR};
  localparam logic [OPC_W-1:0] BRANCH_OPS [0:3] = '{OP_JNZ, OP_JG, OP_JL, OP_JZ};
  localparam logic [OPC_W-1:0] IO_OPS [0:2] = '{OP_INT, OP_IN, OP_OUT};

  typedef struct {
    logic [OPC_W-1:0]  opcode;
    logic              dst_is_addr;
    logic [OPND_W-1:0] dst_value;
    logic              src_is_addr;
    logic [OPND_W-1:0] src_value;
    logic [OPND_W-1:0] loop_limit;
  } instr_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    word_t             jump_target;
    logic [IOEV_W-1:0] io_event;
    word_t             io_value;
  } exec_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // opcode, dst_value, src_value, loop_limit, zeros
  logic [79:0] s_tdata = '0;
  // dst_is_addr, src_is_addr
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // status, jump_target, io_value, zeros
  logic [71:0] m_tdata;
  // io_event
  logic [1:0]  m_tuser;

  // machine state as the executor should hold it
  bit [31:0] data_mem [0:(1 << MEM_BITS) - 1];
  bit [31:0] stack_mem [0:STACK_SIZE - 1];
  int        stack_cnt;
  bit [31:0] last_word;

  exec_result_t pending_results [$];
  int items_sent;
  int results_seen;
  int error_count;
  bit gaps_on;
  bit stalls_on;
  int stall_left;

  memory_to_memory_instruction_executor #(
    .MEM_ADDR_BITS(MEM_BITS),
    .STACK_DEPTH(STACK_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 800_000);
    $display("Verification failed");
    $finish;
  end

  // value of an operand: memory word or zero-extended immediate
  function automatic word_t operand_of(logic is_addr, logic [OPND_W-1:0] value);
    if (is_addr) return data_mem[value[MEM_BITS-1:0]];
    return {8'd0, value};
  endfunction

  // executes one instruction on the local state and returns its result
  function automatic exec_result_t execute_instr(instr_t ins);
    exec_result_t res;
    word_t s_val;
    word_t d_val;
    word_t r;
    logic [MEM_BITS-1:0] d_idx;
    logic taken;
    res.status = ST_OK;
    res.jump_target = '0;
    res.io_event = IO_NONE;
    res.io_value = '0;
    s_val = operand_of(ins.src_is_addr, ins.src_value);
    d_val = operand_of(ins.dst_is_addr, ins.dst_value);
    d_idx = ins.dst_value[MEM_BITS-1:0];
    case (ins.opcode)
      OP_NOP: ;
      OP_MOV, OP_ADD, OP_SUB, OP_NOT, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
        if (!ins.dst_is_addr) begin
          res.status = ST_ERR;
        end else begin
          r = data_mem[d_idx];
          case (ins.opcode)
            OP_MOV:  r = s_val;
            OP_ADD:  r = r + s_val;
            OP_SUB:  r = r - s_val;
            OP_NOT:  r = ~r;
            OP_AND:  r = r & s_val;
            OP_OR:   r = r | s_val;
            OP_XOR:  r = r ^ s_val;
            OP_SHL:  r = r << s_val[4:0];
            default: r = r >> s_val[4:0];
          endcase
          data_mem[d_idx] = r;
          last_word = r;
        end
      end
      OP_INT: begin
        res.io_event = IO_INT;
        res.io_value = d_val;
        last_word = d_val;
      end
      OP_JMP, OP_JNZ, OP_JG, OP_JL, OP_JZ: begin
        case (ins.opcode)
          OP_JMP:  taken = 1'b1;
          OP_JNZ:  taken = (last_word != 0);
          OP_JG:   taken = ($signed(last_word) > 0);
          OP_JL:   taken = last_word[31];
          default: taken = (last_word == 0);
        endcase
        if (taken) begin
          res.status = ST_JUMP;
          res.jump_target = d_val * 3;
          last_word = res.jump_target;
        end
      end
      OP_HLT: res.status = ST_HALT;
      OP_PUSH: begin
        if (stack_cnt >= STACK_SIZE) begin
          res.status = ST_ERR;
        end else begin
          stack_mem[stack_cnt] = d_val;
          last_word = d_val;
          stack_cnt++;
        end
      end
      OP_POP: begin
        if (stack_cnt == 0 || !ins.dst_is_addr) begin
          res.status = ST_ERR;
        end else begin
          r = stack_mem[stack_cnt - 1];
          data_mem[d_idx] = r;
          last_word = r;
          stack_cnt--;
        end
      end
      OP_CMP: last_word = d_val - s_val;
      OP_LOOP: begin
        if (!ins.dst_is_addr) begin
          res.status = ST_ERR;
        end else begin
          r = data_mem[d_idx];
          // count down to zero, or count up to the limit
          if (ins.loop_limit == 0) begin
            if (r != 0) begin
              res.status = ST_JUMP;
              res.jump_target = s_val;
              r = r - 3;
              if (r == ALL_ONES) r = IMM_MAX;
              data_mem[d_idx] = r;
            end
          end else if (r < {8'd0, ins.loop_limit}) begin
            res.status = ST_JUMP;
            res.jump_target = s_val;
            r = r + 3;
            if (r == IMM_MAX) r = '0;
            data_mem[d_idx] = r;
          end
        end
      end
      OP_RST: res.status = ST_RESET;
      OP_IN: begin
        if (!ins.dst_is_addr) begin
          res.status = ST_ERR;
        end else begin
          res.io_event = IO_IN;
          res.io_value = {8'd0, ins.dst_value};
          last_word = {8'd0, ins.dst_value};
        end
      end
      OP_OUT: begin
        res.io_event = IO_OUT;
        res.io_value = d_val;
        last_word = d_val;
      end
      default: res.status = ST_ERR;
    endcase
    return res;
  endfunction

  function automatic instr_t make_instr(logic [OPC_W-1:0] opc, logic da, logic [OPND_W-1:0] dv,
                                        logic sa, logic [OPND_W-1:0] sv,
                                        logic [OPND_W-1:0] lim);
    instr_t ins;
    ins.opcode = opc;
    ins.dst_is_addr = da;
    ins.dst_value = dv;
    ins.src_is_addr = sa;
    ins.src_value = sv;
    ins.loop_limit = lim;
    return ins;
  endfunction

  // immediates biased toward the extremes
  function automatic logic [OPND_W-1:0] rand_imm();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom_range(1, 16));
      3:       return 24'(1) << $urandom_range(0, 23);
      default: return 24'($urandom);
    endcase
  endfunction

  // addresses mostly from a small pool, often with upper bits that wrap away
  function automatic logic [OPND_W-1:0] rand_addr();
    case ($urandom_range(0, 7))
      0:       return 24'($urandom);
      1:       return {8'($urandom), 16'($urandom_range(0, 15))};
      default: return 24'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    if ($urandom_range(0, 15) == 0) begin
      ins.opcode = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end else begin
      ins.opcode = 5'($urandom_range(OP_NOP, OP_OUT));
    end
    ins.dst_is_addr = ($urandom_range(0, 7) != 0);
    ins.dst_value = ins.dst_is_addr ? rand_addr() : rand_imm();
    ins.src_is_addr = 1'($urandom_range(0, 1));
    ins.src_value = ins.src_is_addr ? rand_addr() : rand_imm();
    ins.loop_limit = rand_imm();
    return ins;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    if (error_count < 40) begin
      $display("result %0d: %s is %h, expected %h", results_seen, what, got, want);
    end
    error_count++;
  endtask

  // sends one item, predicts its result once accepted
  task automatic issue_instr(instr_t ins);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, ins.loop_limit, ins.src_value, ins.dst_value, ins.opcode};
    s_tuser <= {ins.src_is_addr, ins.dst_is_addr};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(execute_instr(ins));
    items_sent++;
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    exec_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected item, status", 32'(m_tdata[2:0]), '0);
      return;
    end
    want = pending_results.pop_front();
    if (m_tdata[2:0] !== want.status)
      report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
    if (m_tdata[34:3] !== want.jump_target)
      report_mismatch("jump_target", m_tdata[34:3], want.jump_target);
    if (m_tuser !== want.io_event)
      report_mismatch("io_event", 32'(m_tuser), 32'(want.io_event));
    if (m_tdata[66:35] !== want.io_value)
      report_mismatch("io_value", m_tdata[66:35], want.io_value);
    results_seen++;
  endtask

  // result side: random stall bursts and checking
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        stall_left <= $urandom_range(0, 13);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic test_alu_ops();
    // immediate destination is rejected
    issue_instr(make_instr(OP_MOV, 1'b0, 24'h00_0001, 1'b0, 24'h00_0005, '0));
    // upper address bits wrap onto word 5
    issue_instr(make_instr(OP_MOV, 1'b1, 24'hAB_0005, 1'b0, 24'hFF_FFFF, '0));
    issue_instr(make_instr(OP_ADD, 1'b1, 24'h00_0005, 1'b1, 24'hFF_0005, '0));
    issue_instr(make_instr(OP_SUB, 1'b1, 24'h00_0005, 1'b0, 24'hFF_FFFF, '0));
    issue_instr(make_instr(OP_NOT, 1'b1, 24'h00_0006, 1'b0, '0, '0));
    issue_instr(make_instr(OP_AND, 1'b1, 24'h00_0006, 1'b1, 24'h00_0005, '0));
    issue_instr(make_instr(OP_OR,  1'b1, 24'h00_0007, 1'b0, 24'hAA_AAAA, '0));
    issue_instr(make_instr(OP_XOR, 1'b1, 24'h00_0007, 1'b1, 24'h00_0006, '0));
    // shift counts use the low five bits only
    issue_instr(make_instr(OP_SHL, 1'b1, 24'h00_0007, 1'b0, 24'hFF_FFFF, '0));
    issue_instr(make_instr(OP_SHR, 1'b1, 24'h00_0006, 1'b0, 24'h00_0021, '0));
    // compare wraps below zero
    issue_instr(make_instr(OP_CMP, 1'b0, '0, 1'b0, 24'h00_0001, '0));
  endtask

  task automatic test_jumps();
    issue_instr(make_instr(OP_JL,  1'b0, 24'hFF_FFFF, 1'b0, '0, '0));
    issue_instr(make_instr(OP_JG,  1'b1, 24'h00_0006, 1'b0, '0, '0));
    issue_instr(make_instr(OP_CMP, 1'b1, 24'h00_0005, 1'b1, 24'h00_0005, '0));
    issue_instr(make_instr(OP_JZ,  1'b0, 24'h00_0010, 1'b0, '0, '0));
    issue_instr(make_instr(OP_JNZ, 1'b0, '0, 1'b0, '0, '0));
    // flag now zero, so this one falls through
    issue_instr(make_instr(OP_JNZ, 1'b0, 24'h00_0001, 1'b0, '0, '0));
    issue_instr(make_instr(OP_JMP, 1'b1, 24'h00_0007, 1'b0, '0, '0));
    issue_instr(make_instr(OP_HLT, 1'b0, '0, 1'b0, '0, '0));
    issue_instr(make_instr(OP_RST, 1'b0, '0, 1'b0, '0, '0));
    issue_instr(make_instr(OP_NOP, 1'b1, 24'hFF_FFFF, 1'b1, 24'hFF_FFFF, 24'hFF_FFFF));
    issue_instr(make_instr(OP_LAST_UNUSED, 1'b1, 24'h00_0005, 1'b0, '0, '0));
  endtask

  task automatic test_stack_and_io();
    // pop on an empty stack
    issue_instr(make_instr(OP_POP,  1'b1, 24'h00_0008, 1'b0, '0, '0));
    issue_instr(make_instr(OP_PUSH, 1'b0, 24'hFF_FFFF, 1'b0, '0, '0));
    issue_instr(make_instr(OP_PUSH, 1'b1, 24'h00_0005, 1'b0, '0, '0));
    issue_instr(make_instr(OP_POP,  1'b1, 24'h00_0008, 1'b0, '0, '0));
    issue_instr(make_instr(OP_INT,  1'b1, 24'h00_0007, 1'b0, '0, '0));
    issue_instr(make_instr(OP_IN,   1'b1, 24'hFF_FFFF, 1'b0, '0, '0));
    issue_instr(make_instr(OP_OUT,  1'b1, 24'h00_0008, 1'b0, '0, '0));
  endtask

  task automatic test_loops();
    // count down from 2 lands on the all-ones wrap
    issue_instr(make_instr(OP_MOV,  1'b1, 24'h00_000A, 1'b0, 24'h00_0002, '0));
    issue_instr(make_instr(OP_LOOP, 1'b1, 24'h00_000A, 1'b0, 24'h12_3456, '0));
    // count up into the 24-bit wrap
    issue_instr(make_instr(OP_MOV,  1'b1, 24'h00_000B, 1'b0, 24'hFF_FFFC, '0));
    issue_instr(make_instr(OP_LOOP, 1'b1, 24'h00_000B, 1'b1, 24'h00_000A, 24'hFF_FFFF));
    // zero counter falls through
    issue_instr(make_instr(OP_LOOP, 1'b1, 24'h00_000B, 1'b0, 24'h00_0007, '0));
  endtask

  task automatic test_stack_limits();
    instr_t ins;
    // fill, overflow once, drain, underflow once
    while (stack_cnt <= STACK_SIZE) begin
      ins = rand_instr();
      ins.opcode = OP_PUSH;
      issue_instr(ins);
      if (stack_cnt == STACK_SIZE) begin
        issue_instr(ins);
        break;
      end
    end
    while (stack_cnt > 0) begin
      ins = rand_instr();
      ins.opcode = OP_POP;
      ins.dst_is_addr = 1'b1;
      ins.dst_value = rand_addr();
      issue_instr(ins);
    end
    issue_instr(ins);
  endtask

  task automatic test_random_programs(int n);
    instr_t ins;
    int stop;
    int k;
    logic [OPND_W-1:0] ctr;
    logic [OPND_W-1:0] lim;
    stop = items_sent + n;
    while (items_sent < stop) begin
      case ($urandom_range(0, 5))
        // stray instruction
        0: issue_instr(rand_instr());
        // compare, then a conditional branch
        1: begin
          ins = rand_instr();
          ins.opcode = OP_CMP;
          issue_instr(ins);
          ins = rand_instr();
          ins.opcode = BRANCH_OPS[$urandom_range(0, 3)];
          issue_instr(ins);
        end
        // counter setup followed by several loop steps
        2: begin
          ctr = rand_addr();
          ins = rand_instr();
          ins.opcode = OP_MOV;
          ins.dst_is_addr = 1'b1;
          ins.dst_value = ctr;
          ins.src_is_addr = 1'b0;
          case ($urandom_range(0, 3))
            0:       ins.src_value = 24'($urandom_range(0, 12));
            1:       ins.src_value = 24'hFF_FFF0 + 24'($urandom_range(0, 12));
            2:       ins.src_value = 24'($urandom_range(1, 2));
            default: ins.src_value = rand_imm();
          endcase
          issue_instr(ins);
          lim = ($urandom_range(0, 1) == 0) ? '0 : rand_imm();
          k = $urandom_range(1, 6);
          repeat (k) begin
            ins = rand_instr();
            ins.opcode = OP_LOOP;
            ins.dst_is_addr = 1'b1;
            ins.dst_value = ctr;
            ins.loop_limit = lim;
            issue_instr(ins);
          end
        end
        // arithmetic chain on one word, then output it
        3: begin
          ctr = rand_addr();
          ins = rand_instr();
          ins.opcode = OP_MOV;
          ins.dst_is_addr = 1'b1;
          ins.dst_value = ctr;
          issue_instr(ins);
          k = $urandom_range(2, 5);
          repeat (k) begin
            ins = rand_instr();
            ins.opcode = ALU_OPS[$urandom_range(1, 8)];
            ins.dst_is_addr = 1'b1;
            ins.dst_value = ctr;
            issue_instr(ins);
          end
          ins = rand_instr();
          ins.opcode = OP_OUT;
          ins.dst_is_addr = 1'b1;
          ins.dst_value = ctr;
          issue_instr(ins);
        end
        // pushes, then pops that may run past the bottom
        4: begin
          k = $urandom_range(1, 6);
          repeat (k) begin
            ins = rand_instr();
            ins.opcode = OP_PUSH;
            issue_instr(ins);
          end
          k = $urandom_range(1, k + 1);
          repeat (k) begin
            ins = rand_instr();
            ins.opcode = OP_POP;
            issue_instr(ins);
          end
        end
        default: begin
          ins = rand_instr();
          ins.opcode = IO_OPS[$urandom_range(0, 2)];
          issue_instr(ins);
        end
      endcase
    end
  endtask

  initial begin
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_alu_ops();
    test_jumps();
    test_stack_and_io();
    test_loops();
    test_stack_limits();
    test_random_programs(500);
    hold_until_drained();
    test_random_programs(300);
    // closing stretch at full rate on both sides
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random_programs(200);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
